FILE: src/bdr_pkg.sv
package bdr_pkg;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 16;

	localparam logic [7:0] LOCKOUT_RESET = 8'd25;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_DELAY   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTVL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT      = 2'd3;

	// trigger modes
	localparam logic [1:0] TRIG_PRESS   = 2'd0;
	localparam logic [1:0] TRIG_RELEASE = 2'd1;
	localparam logic [1:0] TRIG_BOTH    = 2'd2;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_PRESS   = 2'd1,
		EV_RELEASE = 2'd2,
		EV_REPEAT  = 2'd3
	} event_t;

	typedef struct packed {
		logic [1:0]  trigger_mode;
		logic [15:0] hold_delay_ms;
		logic [15:0] repeat_interval_ms;
		logic [7:0]  lockout_ms;
	} cfg_t;

	typedef struct packed {
		logic              pressed_level;
		logic [TIME_W-1:0] now_ms;
	} poll_t;

	typedef struct packed {
		event_t event_code;
		logic   notify;
		logic   debounced_level;
	} result_t;

endpackage

FILE: src/bdr_in_if.sv
interface bdr_in_if;
	logic        valid;
	logic        ready;
	logic        pressed_level;
	logic [31:0] now_ms;

	modport source (output valid, output pressed_level, output now_ms, input ready);
	modport sink   (input valid, input pressed_level, input now_ms, output ready);
endinterface

FILE: src/bdr_out_if.sv
interface bdr_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] event_code;
	logic       notify;
	logic       debounced_level;

	modport source (output valid, output event_code, output notify,
		output debounced_level, input ready);
	modport sink   (input valid, input event_code, input notify,
		input debounced_level, output ready);
endinterface

FILE: src/bdr_cfg_regs.sv
module bdr_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bdr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bdr_pkg::CFG_DAT_W-1:0] cfg_wdata,
	output bdr_pkg::cfg_t                 cfg
);

	bdr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_mode       <= bdr_pkg::TRIG_PRESS;
			cfg_q.hold_delay_ms      <= '0;
			cfg_q.repeat_interval_ms <= '0;
			cfg_q.lockout_ms         <= bdr_pkg::LOCKOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bdr_pkg::CFG_TRIGGER_MODE: cfg_q.trigger_mode       <= cfg_wdata[1:0];
				bdr_pkg::CFG_HOLD_DELAY:   cfg_q.hold_delay_ms      <= cfg_wdata[15:0];
				bdr_pkg::CFG_REPEAT_INTVL: cfg_q.repeat_interval_ms <= cfg_wdata[15:0];
				bdr_pkg::CFG_LOCKOUT:      cfg_q.lockout_ms         <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/bdr_eval.sv
module bdr_eval (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  bdr_pkg::poll_t   poll,
	input  bdr_pkg::cfg_t    cfg,
	output bdr_pkg::result_t res
);

	logic                       stable_q;
	logic [bdr_pkg::TIME_W-1:0] last_edge_q;
	logic [bdr_pkg::TIME_W-1:0] last_rep_q;

	logic [bdr_pkg::TIME_W-1:0] since_edge;
	logic [bdr_pkg::TIME_W-1:0] since_rep;
	logic                       edge_ok;
	logic                       rep_ok;
	logic                       edge_notify;

	// wrapping differences
	assign since_edge = poll.now_ms - last_edge_q;
	assign since_rep  = poll.now_ms - last_rep_q;

	assign edge_ok = (since_edge >= {24'd0, cfg.lockout_ms})
		&& (poll.pressed_level != stable_q);

	assign rep_ok = !edge_ok && stable_q
		&& ((cfg.hold_delay_ms != '0) || (cfg.repeat_interval_ms != '0))
		&& (since_edge > {16'd0, cfg.hold_delay_ms})
		&& (since_rep > {16'd0, cfg.repeat_interval_ms});

	always_comb begin
		unique case (cfg.trigger_mode)
			bdr_pkg::TRIG_PRESS:   edge_notify = poll.pressed_level;
			bdr_pkg::TRIG_RELEASE: edge_notify = !poll.pressed_level;
			bdr_pkg::TRIG_BOTH:    edge_notify = 1'b1;
			default:               edge_notify = 1'b0;
		endcase
	end

	always_comb begin
		priority if (edge_ok) begin
			res.event_code = poll.pressed_level ? bdr_pkg::EV_PRESS : bdr_pkg::EV_RELEASE;
			res.notify     = edge_notify;
		end else if (rep_ok) begin
			res.event_code = bdr_pkg::EV_REPEAT;
			res.notify     = 1'b1;
		end else begin
			res.event_code = bdr_pkg::EV_NONE;
			res.notify     = 1'b0;
		end
		res.debounced_level = edge_ok ? poll.pressed_level : stable_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q    <= 1'b0;
			last_edge_q <= '0;
			last_rep_q  <= '0;
		end else if (fire) begin
			if (edge_ok) begin
				stable_q    <= poll.pressed_level;
				last_edge_q <= poll.now_ms;
			end
			if (rep_ok) begin
				last_rep_q <= poll.now_ms;
			end
		end
	end

	a_repeat_notifies: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (res.event_code == bdr_pkg::EV_REPEAT) |-> res.notify)
		else $error("repeat without notify");

	a_edge_updates_level: assert property (@(posedge clk) disable iff (!arst_n)
		fire && edge_ok |=> (stable_q == $past(poll.pressed_level))
			&& (last_edge_q == $past(poll.now_ms)))
		else $error("edge did not update state");

	a_level_held: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && edge_ok) |=> $stable(stable_q) && $stable(last_edge_q))
		else $error("stable level changed without edge");

	a_repeat_needs_press: assert property (@(posedge clk) disable iff (!arst_n)
		rep_ok |-> stable_q && !edge_ok)
		else $error("repeat while released or on edge poll");

endmodule

FILE: src/button_debounce_edge_hold_repeat_core.sv
// Path: an accepted poll transaction passes the input register, evaluation and state
//   update, then the result register.
// Throughput: one poll per clock unless stalled; the loop is bdr_eval's state update.
// Reset: arst_n clears both stage valids, the debounce state (released, times zero) and
//   the config registers to press-only, no repeat, 25 ms lockout.
module button_debounce_edge_hold_repeat_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bdr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bdr_pkg::CFG_DAT_W-1:0] cfg_wdata,
	bdr_in_if.sink                        in_ch,
	bdr_out_if.source                     out_ch
);

	bdr_pkg::cfg_t    cfg;
	bdr_pkg::poll_t   poll_s1;
	bdr_pkg::result_t res;
	bdr_pkg::result_t res_s2;
	logic             valid_s1;
	logic             valid_s2;
	logic             adv;     // stage 1 moves into the result register
	logic             in_take;

	// result register frees when empty or when its transaction completes
	assign adv     = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_take = in_ch.valid && in_ch.ready;
	assign in_ch.ready = !valid_s1 || !valid_s2 || out_ch.ready;

	bdr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			poll_s1.pressed_level <= in_ch.pressed_level;
			poll_s1.now_ms        <= in_ch.now_ms;
		end
	end

	// evaluation; state commits only when the poll moves on, so each poll is seen once
	bdr_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.poll   (poll_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ch.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_ch.valid           = valid_s2;
	assign out_ch.event_code      = res_s2.event_code;
	assign out_ch.notify          = res_s2.notify;
	assign out_ch.debounced_level = res_s2.debounced_level;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_ch.ready |=> valid_s2 && $stable(res_s2))
		else $error("pending result overwritten");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(poll_s1))
		else $error("stalled poll lost");

	a_adv_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> valid_s2)
		else $error("advanced poll gave no result");

endmodule

FILE: tb/sv/testbench.sv
module testbench;

	// Trigger mode code with no defined meaning: edges are never notified.
	localparam logic [1:0] TRIG_UNUSED    = 2'd3;
	// Cycles without any transaction before the run is abandoned.
	localparam int         WATCHDOG_LIMIT = 2000;
	// Length of the long output hold-off, in cycles.
	localparam int         HOLD_OFF_CYCLES = 80;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [bdr_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bdr_pkg::CFG_DAT_W-1:0] cfg_wdata;

	bdr_in_if  in_ch ();
	bdr_out_if out_ch ();

	button_debounce_edge_hold_repeat_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always #2 clk = ~clk;

	// Shadow of the configuration registers and of the debounce state.
	bdr_pkg::cfg_t model_cfg;
	logic          deb_level;
	logic [31:0]   edge_stamp;
	logic [31:0]   repeat_stamp;

	// Results predicted for accepted polls, oldest first.
	bdr_pkg::result_t pending_results[$];

	// Pacing knobs, percent of cycles.
	int idle_pct;
	int stall_pct;
	logic rx_hold;

	// Stimulus state: free-running millisecond clock and physical button level.
	logic [31:0] t_ms;
	logic        phys;

	int fail_cnt;
	int quiet_cycles;
	int n_polls;
	int n_press;
	int n_release;
	int n_repeat;
	int n_notify;

	// Next result for one poll; advances the shadow state as the block would.
	function automatic bdr_pkg::result_t predict_poll(input logic level,
			input logic [31:0] now);
		bdr_pkg::result_t r;
		logic [31:0]      since_edge;
		logic [31:0]      since_repeat;
		logic             took_edge;
		r.event_code = bdr_pkg::EV_NONE;
		r.notify     = 1'b0;
		took_edge    = 1'b0;
		since_edge   = now - edge_stamp;
		if (since_edge >= {24'd0, model_cfg.lockout_ms} && level != deb_level) begin
			took_edge  = 1'b1;
			edge_stamp = now;
			deb_level  = level;
			if (level) begin
				r.event_code = bdr_pkg::EV_PRESS;
				r.notify = (model_cfg.trigger_mode == bdr_pkg::TRIG_PRESS) ||
					(model_cfg.trigger_mode == bdr_pkg::TRIG_BOTH);
			end else begin
				r.event_code = bdr_pkg::EV_RELEASE;
				r.notify = (model_cfg.trigger_mode == bdr_pkg::TRIG_RELEASE) ||
					(model_cfg.trigger_mode == bdr_pkg::TRIG_BOTH);
			end
		end
		// an edge poll never repeats, so since_edge is still current here
		since_repeat = now - repeat_stamp;
		if (!took_edge && deb_level &&
				(model_cfg.hold_delay_ms != 16'd0 || model_cfg.repeat_interval_ms != 16'd0) &&
				since_edge > {16'd0, model_cfg.hold_delay_ms} &&
				since_repeat > {16'd0, model_cfg.repeat_interval_ms}) begin
			repeat_stamp = now;
			r.event_code = bdr_pkg::EV_REPEAT;
			r.notify     = 1'b1;
		end
		r.debounced_level = deb_level;
		return r;
	endfunction

	// Output pacing; rx_hold forces a long stall.
	always @(posedge clk) begin
		out_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= stall_pct);
	end

	// Scoreboard: check the output transaction first, then predict the input one,
	// so a result never meets an expectation queued at the same edge.
	always @(posedge clk) begin : scoreboard
		bdr_pkg::result_t got;
		bdr_pkg::result_t want;
		logic             moved;
		if (arst_n) begin
			moved = 1'b0;
			if (out_ch.valid && out_ch.ready) begin
				moved = 1'b1;
				got.event_code      = bdr_pkg::event_t'(out_ch.event_code);
				got.notify          = out_ch.notify;
				got.debounced_level = out_ch.debounced_level;
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result event_code %0d notify %0d level %0d",
						$time, got.event_code, got.notify, got.debounced_level);
					fail_cnt++;
				end else begin
					want = pending_results.pop_front();
					if (got.event_code !== want.event_code) begin
						$display("%0t: event_code expected %0d actual %0d",
							$time, want.event_code, got.event_code);
						fail_cnt++;
					end
					if (got.notify !== want.notify) begin
						$display("%0t: notify expected %0d actual %0d",
							$time, want.notify, got.notify);
						fail_cnt++;
					end
					if (got.debounced_level !== want.debounced_level) begin
						$display("%0t: debounced_level expected %0d actual %0d",
							$time, want.debounced_level, got.debounced_level);
						fail_cnt++;
					end
					case (want.event_code)
						bdr_pkg::EV_PRESS:   n_press++;
						bdr_pkg::EV_RELEASE: n_release++;
						bdr_pkg::EV_REPEAT:  n_repeat++;
						default:             ;
					endcase
					if (want.notify) n_notify++;
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				moved = 1'b1;
				pending_results.push_back(predict_poll(in_ch.pressed_level, in_ch.now_ms));
				n_polls++;
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d results outstanding",
					$time, quiet_cycles, pending_results.size());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Offer one poll, with random idle cycles first; returns at the accepting edge
	// with valid still high so back-to-back transactions need no re-assertion.
	task automatic send_poll(input logic level, input logic [31:0] now);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.pressed_level <= level;
		in_ch.now_ms        <= now;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	// Drop valid and let every outstanding result drain; one edge first so the
	// scoreboard has queued the last accepted poll.
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register write; only called while the block is idle.
	task automatic write_reg(input logic [bdr_pkg::CFG_IDX_W-1:0] idx,
			input logic [bdr_pkg::CFG_DAT_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			bdr_pkg::CFG_TRIGGER_MODE: model_cfg.trigger_mode       = data[1:0];
			bdr_pkg::CFG_HOLD_DELAY:   model_cfg.hold_delay_ms      = data;
			bdr_pkg::CFG_REPEAT_INTVL: model_cfg.repeat_interval_ms = data;
			bdr_pkg::CFG_LOCKOUT:      model_cfg.lockout_ms         = data[7:0];
			default:                   ;
		endcase
	endtask

	// Reset values: press only, no repeat, 25 ms lockout.
	task automatic test_defaults();
		send_poll(1'b1, 32'd0);           // inside lockout from reset: no event
		send_poll(1'b1, 32'd24);
		send_poll(1'b1, 32'd25);          // press, notified
		send_poll(1'b1, 32'd10_000);      // held, repeat disabled
		send_poll(1'b0, 32'd10_005);      // release, filtered out
		send_poll(1'b0, 32'hFFFF_FFFF);
	endtask

	// Release, both, unused modes at zero lockout; polls straddle the time wrap.
	task automatic test_trigger_modes();
		logic [1:0] modes [3];
		modes = '{bdr_pkg::TRIG_RELEASE, bdr_pkg::TRIG_BOTH, TRIG_UNUSED};
		wait_idle();
		write_reg(bdr_pkg::CFG_LOCKOUT, 16'hFF00);  // upper bits ignored: lockout 0
		foreach (modes[i]) begin
			wait_idle();
			write_reg(bdr_pkg::CFG_TRIGGER_MODE, {14'h3FFF, modes[i]});
			send_poll(1'b1, 32'hFFFF_FFFE);
			send_poll(1'b1, 32'hFFFF_FFFF); // steady press: no edge, whatever the mode
			send_poll(1'b0, 32'h0000_0000);
		end
	endtask

	// Hold repeat at the extremes, then the repeat timer surviving a new press.
	task automatic test_hold_repeat();
		wait_idle();
		write_reg(bdr_pkg::CFG_TRIGGER_MODE, {14'd0, bdr_pkg::TRIG_PRESS});
		write_reg(bdr_pkg::CFG_LOCKOUT, 16'd255);
		write_reg(bdr_pkg::CFG_HOLD_DELAY, 16'hFFFF);
		write_reg(bdr_pkg::CFG_REPEAT_INTVL, 16'hFFFF);
		send_poll(1'b1, 32'd300);         // press
		send_poll(1'b1, 32'd65_835);      // exactly the hold delay: not yet
		send_poll(1'b1, 32'd65_836);      // first repeat
		send_poll(1'b1, 32'd131_371);     // exactly the interval: not yet
		send_poll(1'b1, 32'd131_372);     // second repeat
		send_poll(1'b0, 32'd131_373);     // edge poll: release only, no repeat
		wait_idle();
		write_reg(bdr_pkg::CFG_HOLD_DELAY, 16'd0);
		write_reg(bdr_pkg::CFG_REPEAT_INTVL, 16'd1000);
		send_poll(1'b1, 32'd131_628);     // press; repeat timer keeps its old stamp
		send_poll(1'b1, 32'd131_629);
		send_poll(1'b1, 32'd132_373);     // 1001 ms after the last repeat
		wait_idle();
		write_reg(bdr_pkg::CFG_HOLD_DELAY, 16'd50);
		write_reg(bdr_pkg::CFG_REPEAT_INTVL, 16'd0);
		send_poll(1'b1, 32'd132_374);
	endtask

	// Pick a setting, leaning towards the extremes; upper data bits are noise.
	task automatic random_config();
		logic [31:0] r;
		logic [15:0] v;
		wait_idle();
		r = $urandom();
		write_reg(bdr_pkg::CFG_TRIGGER_MODE, {r[15:2], 2'($urandom_range(0, 3))});
		case ($urandom_range(0, 3))
			0:       v = 16'd0;
			1:       v = 16'hFFFF;
			default: v = 16'($urandom_range(1, 300));
		endcase
		write_reg(bdr_pkg::CFG_HOLD_DELAY, v);
		case ($urandom_range(0, 3))
			0:       v = 16'd0;
			1:       v = 16'hFFFF;
			default: v = 16'($urandom_range(1, 200));
		endcase
		write_reg(bdr_pkg::CFG_REPEAT_INTVL, v);
		r = $urandom();
		case ($urandom_range(0, 3))
			0:       v = {r[15:8], 8'd0};
			1:       v = {r[15:8], 8'd255};
			2:       v = {r[15:8], bdr_pkg::LOCKOUT_RESET};
			default: v = r[15:0];
		endcase
		write_reg(bdr_pkg::CFG_LOCKOUT, v);
	endtask

	// Mostly realistic presses: a few bounces, then a steady level polled at
	// varying spacing; one segment in ten is a single noise poll.
	task automatic run_random(input int n_items);
		int          sent;
		int          bounces;
		int          steady;
		logic [31:0] step;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				send_poll(1'($urandom_range(0, 1)), $urandom());
				sent++;
			end else begin
				phys    = ~phys;
				bounces = $urandom_range(0, 4);
				steady  = $urandom_range(1, 16);
				repeat (bounces) begin
					t_ms += 32'($urandom_range(0, 3));
					send_poll(1'($urandom_range(0, 1)), t_ms);
					sent++;
				end
				repeat (steady) begin
					case ($urandom_range(0, 19))
						0:       step = $urandom();
						1, 2:    step = 32'($urandom_range(100, 2000));
						default: step = 32'($urandom_range(1, 40));
					endcase
					t_ms += step;
					send_poll(phys, t_ms);
					sent++;
				end
				if ($urandom_range(0, 49) == 0) t_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 500));
			end
		end
	endtask

	// Four pacing phases, two settings each.
	task automatic test_random_phases();
		int idles  [4];
		int stalls [4];
		idles  = '{0, 58, 0, 14};
		stalls = '{0, 0, 58, 14};
		foreach (idles[p]) begin
			repeat (2) begin
				random_config();
				idle_pct  = idles[p];
				stall_pct = stalls[p];
				run_random(100);
			end
		end
	endtask

	// Output held off for a long stretch while polls keep coming: the pipe fills
	// and must stall its input without losing a transaction.
	task automatic test_backpressure();
		random_config();
		idle_pct  = 0;
		stall_pct = 0;
		fork
			begin
				rx_hold <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		run_random(40);
	endtask

	initial begin
		clk                 = 1'b0;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = bdr_pkg::CFG_TRIGGER_MODE;
		cfg_wdata           = '0;
		in_ch.valid         = 1'b0;
		in_ch.pressed_level = 1'b0;
		in_ch.now_ms        = '0;
		out_ch.ready        = 1'b0;
		rx_hold             = 1'b0;
		idle_pct            = 0;
		stall_pct           = 0;
		fail_cnt            = 0;
		quiet_cycles        = 0;
		n_polls             = 0;
		n_press             = 0;
		n_release           = 0;
		n_repeat            = 0;
		n_notify            = 0;
		model_cfg           = '{bdr_pkg::TRIG_PRESS, 16'd0, 16'd0, bdr_pkg::LOCKOUT_RESET};
		deb_level           = 1'b0;
		edge_stamp          = '0;
		repeat_stamp        = '0;
		t_ms                = $urandom();
		phys                = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_defaults();
		test_trigger_modes();
		test_hold_repeat();
		test_backpressure();
		test_random_phases();
		wait_idle();
		repeat (8) @(posedge clk);

		$display("Checked %0d polls: %0d press, %0d release, %0d hold repeat, %0d notified",
			n_polls, n_press, n_release, n_repeat, n_notify);
		$display("Covered all trigger modes, lockout and repeat extremes, time wrap, %s",
			"four pacing phases and a long output hold-off");
		if (fail_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
